[design/tvs_pkg.sv]
`default_nettype none
package tvs_pkg;

    // voice store geometry
    localparam int VOICE_COUNT = 3;
    localparam int VIDX_W      = 2;
    localparam int CYC_W       = 11;
    localparam logic [CYC_W-1:0] CYCLE_CAP = 11'd1024;

    localparam logic [22:0] LFSR_SEED = 23'h7FFFF8;

    // input operation codes
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_RENDER = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // chip register map
    localparam logic [4:0] REG_VOICE_END = 5'd21;
    localparam logic [4:0] REG_VOLUME    = 5'd24;

    // configuration register indexes
    localparam logic [1:0] CFG_CLOCK = 2'd0;
    localparam logic [1:0] CFG_RATE  = 2'd1;

    localparam logic [21:0] CLOCK_RESET = 22'd985248;
    localparam logic [17:0] RATE_RESET  = 18'd44100;

    // per-voice register slots
    localparam logic [2:0] SLOT_FREQ_LO = 3'd0;
    localparam logic [2:0] SLOT_FREQ_HI = 3'd1;
    localparam logic [2:0] SLOT_PW_LO   = 3'd2;
    localparam logic [2:0] SLOT_PW_HI   = 3'd3;
    localparam logic [2:0] SLOT_CTRL    = 3'd4;
    localparam logic [2:0] SLOT_AD      = 3'd5;

    // envelope phases
    localparam logic [1:0] PH_ATTACK  = 2'd0;
    localparam logic [1:0] PH_DECAY   = 2'd1;
    localparam logic [1:0] PH_RELEASE = 2'd2;

    typedef struct packed {
        logic [15:0] freq;
        logic [11:0] pw;
        logic [7:0]  ctrl;
        logic [7:0]  ad;
        logic [7:0]  sr;
        logic [23:0] acc;
        logic [22:0] lfsr;
        logic        gate;
        logic        b19;
        logic        msb;
        logic        hold;
        logic [1:0]  phase;
        logic [7:0]  env;
        logic [15:0] rate_cnt;
        logic [4:0]  exp_cnt;
    } voice_t;

    localparam voice_t VOICE_RESET = '{
        freq: 16'd0, pw: 12'd0, ctrl: 8'd0, ad: 8'd0, sr: 8'd0, acc: 24'd0,
        lfsr: LFSR_SEED, gate: 1'b0, b19: 1'b0, msb: 1'b0, hold: 1'b0,
        phase: PH_RELEASE, env: 8'd0, rate_cnt: 16'd0, exp_cnt: 5'd0
    };

    typedef enum logic [2:0] {
        VOP_NONE,
        VOP_READ,
        VOP_REG,
        VOP_OSC,
        VOP_ENV,
        VOP_CLEAR
    } voice_op_t;

    typedef struct packed {
        voice_op_t         op;
        logic [VIDX_W-1:0] idx;
        logic [2:0]        slot;
        logic [7:0]        data;
        logic              sync_rose;
        logic              src_msb;
    } voice_ctl_t;

    typedef struct packed {
        logic        rose;
        logic        msb;
        logic [11:0] wave;
        logic [7:0]  env;
    } voice_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_W_RD,
        S_W_EX,
        S_DIV_RATE,
        S_C_RD,
        S_C_EX,
        S_DRAIN,
        S_DIV_AVG,
        S_FIN
    } state_t;

    // envelope rate periods in chip cycles
    function automatic logic [15:0] env_period(input logic [3:0] r);
        logic [15:0] p;
        case (r)
            4'd0:    p = 16'd9;
            4'd1:    p = 16'd32;
            4'd2:    p = 16'd63;
            4'd3:    p = 16'd95;
            4'd4:    p = 16'd149;
            4'd5:    p = 16'd220;
            4'd6:    p = 16'd267;
            4'd7:    p = 16'd313;
            4'd8:    p = 16'd392;
            4'd9:    p = 16'd977;
            4'd10:   p = 16'd1954;
            4'd11:   p = 16'd3126;
            4'd12:   p = 16'd3907;
            4'd13:   p = 16'd11720;
            4'd14:   p = 16'd19532;
            default: p = 16'd31251;
        endcase
        return p;
    endfunction

    // piecewise exponential divider for decay and release
    function automatic logic [4:0] exp_period(input logic [7:0] lvl);
        logic [4:0] p;
        if (lvl > 8'h5D)      p = 5'd1;
        else if (lvl > 8'h36) p = 5'd2;
        else if (lvl > 8'h1A) p = 5'd4;
        else if (lvl > 8'h0E) p = 5'd8;
        else if (lvl > 8'h06) p = 5'd16;
        else if (lvl > 8'h00) p = 5'd30;
        else                  p = 5'd1;
        return p;
    endfunction

    function automatic logic [11:0] noise_bits(input logic [22:0] s);
        return {s[22], s[20], s[16], s[13], s[11], s[7], s[4], s[2], 4'b0000};
    endfunction

    // register address to voice number and slot
    function automatic logic [VIDX_W-1:0] voice_of(input logic [4:0] addr);
        logic [VIDX_W-1:0] v;
        if (addr < 5'd7)       v = 2'd0;
        else if (addr < 5'd14) v = 2'd1;
        else                   v = 2'd2;
        return v;
    endfunction

    function automatic logic [2:0] slot_of(input logic [4:0] addr);
        logic [4:0] s;
        if (addr < 5'd7)       s = addr;
        else if (addr < 5'd14) s = addr - 5'd7;
        else                   s = addr - 5'd14;
        return s[2:0];
    endfunction

endpackage
`default_nettype wire

[design/tvs_div.sv]
`default_nettype none
module tvs_div
    import tvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [17:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [17:0] remainder
);

    logic [31:0] quo_reg;
    logic [17:0] rem_reg;
    logic [17:0] dsr_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;

    logic [18:0] trial;
    logic        fits;

    // one restoring step per cycle
    assign trial = {rem_reg, quo_reg[31]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= 6'd32;
            end
            else if (cnt_reg != 6'd0)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 18'd0;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != 6'd0)
        begin
            quo_reg <= {quo_reg[30:0], fits};
            rem_reg <= fits ? 18'(trial - {1'b0, dsr_reg}) : trial[17:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

[design/tvs_voice.sv]
`default_nettype none
module tvs_voice
    import tvs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  voice_ctl_t ctl,
    output voice_res_t res
);

    voice_t mem [VOICE_COUNT];
    logic [VOICE_COUNT-1:0] valid_reg;
    voice_t cur_reg;
    voice_t nxt;
    logic   wr_en;

    logic [24:0] acc_sum;
    logic [3:0]  rsel;
    logic [15:0] rc_inc;
    logic [4:0]  exp_inc;
    logic [7:0]  env_up;
    logic [7:0]  env_dn;
    logic        fold;
    logic [23:0] ramp;
    logic        pulse_hi;
    logic [11:0] wv;

    assign wr_en = (ctl.op == VOP_REG) || (ctl.op == VOP_OSC) || (ctl.op == VOP_ENV);

    // voice store: registered read, write back at the same index
    always_ff @(posedge clk)
    begin
        if (ctl.op == VOP_READ)
        begin
            cur_reg <= valid_reg[ctl.idx] ? mem[ctl.idx] : VOICE_RESET;
        end
        if (wr_en)
        begin
            mem[ctl.idx] <= nxt;
        end
    end

    // unwritten entries read as the cleared voice
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ctl.op == VOP_CLEAR)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[ctl.idx] <= 1'b1;
        end
    end

    // modify step
    always_comb
    begin
        nxt     = cur_reg;
        acc_sum = {1'b0, cur_reg.acc} + {9'd0, cur_reg.freq};
        rc_inc  = cur_reg.rate_cnt + 16'd1;
        exp_inc = cur_reg.exp_cnt + 5'd1;
        env_up  = (cur_reg.env == 8'hFF) ? 8'hFF : cur_reg.env + 8'd1;
        env_dn  = (cur_reg.env == 8'd0) ? 8'd0 : cur_reg.env - 8'd1;
        case (cur_reg.phase)
            PH_ATTACK: rsel = cur_reg.ad[7:4];
            PH_DECAY:  rsel = cur_reg.ad[3:0];
            default:   rsel = cur_reg.sr[3:0];
        endcase
        case (ctl.op)
            VOP_REG:
            begin
                case (ctl.slot)
                    SLOT_FREQ_LO: nxt.freq[7:0]  = ctl.data;
                    SLOT_FREQ_HI: nxt.freq[15:8] = ctl.data;
                    SLOT_PW_LO:   nxt.pw[7:0]    = ctl.data;
                    SLOT_PW_HI:   nxt.pw[11:8]   = ctl.data[3:0];
                    SLOT_CTRL:
                    begin
                        // gate edges start attack or release
                        if (ctl.data[0] && !cur_reg.gate)
                        begin
                            nxt.phase = PH_ATTACK;
                            nxt.hold  = 1'b0;
                        end
                        else if (!ctl.data[0] && cur_reg.gate)
                        begin
                            nxt.phase = PH_RELEASE;
                        end
                        nxt.gate = ctl.data[0];
                        nxt.ctrl = ctl.data;
                        if (ctl.data[3])
                        begin
                            nxt.acc  = 24'd0;
                            nxt.lfsr = LFSR_SEED;
                        end
                    end
                    SLOT_AD:      nxt.ad = ctl.data;
                    default:      nxt.sr = ctl.data;
                endcase
            end
            VOP_OSC:
            begin
                if (cur_reg.ctrl[3])
                begin
                    nxt.acc = 24'd0;
                    nxt.b19 = 1'b0;
                    nxt.msb = 1'b0;
                end
                else
                begin
                    nxt.acc = acc_sum[23:0];
                    nxt.b19 = acc_sum[19];
                    nxt.msb = acc_sum[23];
                    // noise clocks on a rising bit 19
                    if (acc_sum[19] && !cur_reg.b19)
                    begin
                        nxt.lfsr = {cur_reg.lfsr[21:0], cur_reg.lfsr[22] ^ cur_reg.lfsr[17]};
                    end
                end
            end
            VOP_ENV:
            begin
                // hard sync from the preceding voice
                if (ctl.sync_rose && cur_reg.ctrl[1])
                begin
                    nxt.acc = 24'd0;
                end
                if (rc_inc < env_period(rsel))
                begin
                    nxt.rate_cnt = rc_inc;
                end
                else
                begin
                    nxt.rate_cnt = 16'd0;
                    if (cur_reg.phase == PH_ATTACK)
                    begin
                        nxt.env = env_up;
                        if (env_up == 8'hFF)
                        begin
                            nxt.phase = PH_DECAY;
                        end
                    end
                    else if (exp_inc < exp_period(cur_reg.env))
                    begin
                        nxt.exp_cnt = exp_inc;
                    end
                    else
                    begin
                        nxt.exp_cnt = 5'd0;
                        if (!cur_reg.hold)
                        begin
                            if (cur_reg.phase == PH_DECAY)
                            begin
                                if (cur_reg.env > {cur_reg.sr[7:4], cur_reg.sr[7:4]})
                                begin
                                    nxt.env = env_dn;
                                end
                            end
                            else
                            begin
                                nxt.env = env_dn;
                                if (env_dn == 8'd0)
                                begin
                                    nxt.hold = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // waveform select; mid-scale code stands for a silent voice
    always_comb
    begin
        fold     = nxt.acc[23] ^ (nxt.ctrl[2] & ctl.src_msb);
        ramp     = fold ? ~nxt.acc : nxt.acc;
        pulse_hi = nxt.ctrl[3] || (nxt.acc[23:12] >= nxt.pw);
        wv       = 12'hFFF;
        if (nxt.ctrl[4])
        begin
            wv = wv & ramp[22:11];
        end
        if (nxt.ctrl[5])
        begin
            wv = wv & nxt.acc[23:12];
        end
        if (nxt.ctrl[6])
        begin
            wv = wv & {12{pulse_hi}};
        end
        if (nxt.ctrl[7])
        begin
            wv = wv & noise_bits(nxt.lfsr);
        end
        if ((nxt.ctrl[7:4] == 4'd0) || (nxt.env == 8'd0))
        begin
            wv = 12'h800;
        end
    end

    assign res.rose = !cur_reg.msb && nxt.msb;
    assign res.msb  = nxt.msb;
    assign res.wave = wv;
    assign res.env  = nxt.env;

endmodule
`default_nettype wire

[design/three_voice_sound_synth.sv]
// Render: a cycle-count divide, then per chip cycle two read/write passes over
// the voice store, a pipeline drain and an averaging divide; a zero rate or
// cycle count skips straight to the result. A register write reads and writes
// back one voice entry; clear and volume write act on acceptance. One word at a time.
// Asynchronous active-low reset; voice store entries read as cleared through
// per-entry valid bits, so no clearing pass is needed.
`default_nettype none
module three_voice_sound_synth
    import tvs_pkg::*;
#(
    parameter int MIX_SHIFT = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_enable,
    input  logic [1:0]         cfg_index,
    input  logic [21:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         operation,
    input  logic [4:0]         register_address,
    input  logic [7:0]         write_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] sample_out
);

    state_t state_reg, state_next;

    logic [21:0] clock_reg;
    logic [17:0] rate_reg;
    logic [17:0] frac_reg;
    logic [3:0]  volume_reg;

    logic [VIDX_W-1:0] cmd_idx_reg;
    logic [2:0]        cmd_slot_reg;
    logic [7:0]        cmd_data_reg;

    logic [VIDX_W-1:0]      vidx_reg;
    logic [VIDX_W-1:0]      src_idx;
    logic                   pass_reg;
    logic [CYC_W-1:0]       cyc_total_reg;
    logic [CYC_W-1:0]       cyc_left_reg;
    logic [VOICE_COUNT-1:0] rose_reg;
    logic [VOICE_COUNT-1:0] msb_reg;

    logic               term_valid_reg;
    logic [11:0]        wave_reg;
    logic [7:0]         env_reg;
    logic               prod_valid_reg;
    logic signed [20:0] prod_reg;
    logic signed [31:0] sum_reg;
    logic signed [31:0] mixed_reg;
    logic signed [31:0] shifted;

    logic               out_valid_reg;
    logic signed [15:0] sample_reg;

    logic        accept;
    logic        last_step;
    logic        pipe_empty;
    logic        out_free;
    logic [22:0] total;
    logic [31:0] sum_abs;
    logic [31:0] q_signed;
    logic [36:0] scaled;

    voice_ctl_t  vctl;
    voice_res_t  vres;
    logic        div_start;
    logic [31:0] div_dividend;
    logic [17:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quotient;
    logic [17:0] div_remainder;

    tvs_voice u_voice (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (vctl),
        .res   (vres)
    );

    tvs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    assign in_ready   = (state_reg == S_IDLE);
    assign accept     = in_valid && in_ready;
    assign last_step  = (vidx_reg == VIDX_W'(VOICE_COUNT - 1)) && pass_reg &&
                        (cyc_left_reg == CYC_W'(1));
    assign pipe_empty = !term_valid_reg && !prod_valid_reg;
    assign out_free   = !out_valid_reg || out_ready;
    assign src_idx    = (vidx_reg == 2'd0) ? VIDX_W'(VOICE_COUNT - 1) : vidx_reg - 2'd1;
    assign total      = {5'd0, frac_reg} + {1'b0, clock_reg};
    assign sum_abs    = sum_reg[31] ? 32'(-sum_reg) : 32'(sum_reg);
    assign q_signed   = sum_reg[31] ? 32'(-div_quotient) : div_quotient;
    assign scaled     = 37'($signed(q_signed) * $signed({1'b0, volume_reg}));
    assign shifted    = mixed_reg >>> MIX_SHIFT;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (operation == OP_WRITE && register_address < REG_VOICE_END)
                    begin
                        state_next = S_W_RD;
                    end
                    else if (operation == OP_RENDER)
                    begin
                        state_next = (rate_reg == 18'd0) ? S_FIN : S_DIV_RATE;
                    end
                end
            end
            S_W_RD:     state_next = S_W_EX;
            S_W_EX:     state_next = S_IDLE;
            S_DIV_RATE:
            begin
                if (div_done)
                begin
                    state_next = (div_quotient == 32'd0) ? S_FIN : S_C_RD;
                end
            end
            S_C_RD:     state_next = S_C_EX;
            S_C_EX:     state_next = last_step ? S_DRAIN : S_C_RD;
            S_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = S_DIV_AVG;
                end
            end
            S_DIV_AVG:
            begin
                if (div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // outputs toward the voice store and divider
    always_comb
    begin
        vctl.op        = VOP_NONE;
        vctl.idx       = vidx_reg;
        vctl.slot      = cmd_slot_reg;
        vctl.data      = cmd_data_reg;
        vctl.sync_rose = rose_reg[src_idx];
        vctl.src_msb   = msb_reg[src_idx];
        div_start      = 1'b0;
        div_dividend   = {9'd0, total};
        div_divisor    = rate_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && operation == OP_CLEAR)
                begin
                    vctl.op = VOP_CLEAR;
                end
                div_start = accept && (operation == OP_RENDER) && (rate_reg != 18'd0);
            end
            S_W_RD:
            begin
                vctl.op  = VOP_READ;
                vctl.idx = cmd_idx_reg;
            end
            S_W_EX:
            begin
                vctl.op  = VOP_REG;
                vctl.idx = cmd_idx_reg;
            end
            S_C_RD:     vctl.op = VOP_READ;
            S_C_EX:     vctl.op = pass_reg ? VOP_ENV : VOP_OSC;
            S_DRAIN:
            begin
                div_start    = pipe_empty;
                div_dividend = sum_abs;
                div_divisor  = {7'd0, cyc_total_reg};
            end
            default:
            begin
            end
        endcase
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg <= CLOCK_RESET;
            rate_reg  <= RATE_RESET;
        end
        else if (cfg_write_enable)
        begin
            if (cfg_index == CFG_CLOCK)
            begin
                clock_reg <= cfg_data;
            end
            else if (cfg_index == CFG_RATE)
            begin
                rate_reg <= cfg_data[17:0];
            end
        end
    end

    // control state and sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            frac_reg       <= 18'd0;
            volume_reg     <= 4'd0;
            vidx_reg       <= '0;
            pass_reg       <= 1'b0;
            cyc_left_reg   <= '0;
            cyc_total_reg  <= '0;
            rose_reg       <= '0;
            msb_reg        <= '0;
            term_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            term_valid_reg <= (state_reg == S_C_EX) && pass_reg;
            prod_valid_reg <= term_valid_reg;
            // result word: a new one may replace the one just taken
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (operation == OP_WRITE && register_address == REG_VOLUME)
                        begin
                            volume_reg <= write_data[3:0];
                        end
                        else if (operation == OP_CLEAR)
                        begin
                            volume_reg <= 4'd0;
                            frac_reg   <= 18'd0;
                        end
                        else if (operation == OP_RENDER && rate_reg == 18'd0)
                        begin
                            frac_reg <= 18'd0;
                        end
                    end
                end
                S_DIV_RATE:
                begin
                    if (div_done)
                    begin
                        frac_reg <= div_remainder;
                        vidx_reg <= '0;
                        pass_reg <= 1'b0;
                        if (div_quotient > {21'd0, CYCLE_CAP})
                        begin
                            cyc_total_reg <= CYCLE_CAP;
                            cyc_left_reg  <= CYCLE_CAP;
                        end
                        else
                        begin
                            cyc_total_reg <= div_quotient[CYC_W-1:0];
                            cyc_left_reg  <= div_quotient[CYC_W-1:0];
                        end
                    end
                end
                S_C_EX:
                begin
                    if (!pass_reg)
                    begin
                        rose_reg[vidx_reg] <= vres.rose;
                        msb_reg[vidx_reg]  <= vres.msb;
                    end
                    if (vidx_reg == VIDX_W'(VOICE_COUNT - 1))
                    begin
                        vidx_reg <= '0;
                        pass_reg <= !pass_reg;
                        if (pass_reg)
                        begin
                            cyc_left_reg <= cyc_left_reg - CYC_W'(1);
                        end
                    end
                    else
                    begin
                        vidx_reg <= vidx_reg + 2'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // payload: command capture, mix pipeline, result
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_idx_reg  <= voice_of(register_address);
            cmd_slot_reg <= slot_of(register_address);
            cmd_data_reg <= write_data;
        end
        if (state_reg == S_C_EX)
        begin
            wave_reg <= vres.wave;
            env_reg  <= vres.env;
        end
        prod_reg <= 21'(($signed({1'b0, wave_reg}) - 13'sd2048) * $signed({1'b0, env_reg}));
        if (state_reg == S_DIV_RATE)
        begin
            sum_reg <= 32'sd0;
        end
        else if (prod_valid_reg)
        begin
            sum_reg <= sum_reg + 32'(prod_reg);
        end
        if (state_reg == S_IDLE || state_reg == S_DIV_RATE)
        begin
            mixed_reg <= 32'sd0;
        end
        else if (state_reg == S_DIV_AVG && div_done)
        begin
            mixed_reg <= $signed(scaled[31:0]);
        end
        if (state_reg == S_FIN && out_free)
        begin
            sample_reg <= shifted[15:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_reg;

`ifndef SYNTHESIS
    // a running render always has chip cycles left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C_RD || state_reg == S_C_EX) |-> (cyc_left_reg != '0))
        else $error("chip cycle counter ran out during render");

    // voice index stays within the store
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_C_RD || state_reg == S_C_EX) |-> (vidx_reg != 2'd3))
        else $error("voice index out of range");

    // render with a nonzero rate starts the cycle-count divide
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && operation == OP_RENDER && rate_reg != 18'd0) |=>
            (state_reg == S_DIV_RATE))
        else $error("render did not start divide");

    // the drain hands off only with an empty multiply pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_AVG && $past(state_reg) == S_DRAIN) |-> pipe_empty)
        else $error("averaging started before mix pipe drained");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import tvs_pkg::*;

    localparam int SHIFT_BITS  = 10;
    localparam int CYCLE_LIMIT = 40000000;
    localparam int MAX_SHOWN   = 10;

    // bit 3 of a voice control byte holds the oscillator in test
    localparam logic [7:0] CTRL_TEST = 8'h08;

    // codes with no function in the block
    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_write_enable;
    logic [1:0]         cfg_index;
    logic [21:0]        cfg_data;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         operation;
    logic [4:0]         register_address;
    logic [7:0]         write_data;
    logic               out_valid;
    logic               out_ready;
    logic signed [15:0] sample_out;

    three_voice_sound_synth #(.MIX_SHIFT(SHIFT_BITS)) u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .operation        (operation),
        .register_address (register_address),
        .write_data       (write_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .sample_out       (sample_out)
    );

    // clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Synth model: voice registers, oscillators and envelopes
    // ------------------------------------------------------------------
    localparam int unsigned RATE_TICKS [16] = '{
        9, 32, 63, 95, 149, 220, 267, 313, 392, 977, 1954, 3126, 3907, 11720, 19532, 31251
    };

    logic [21:0] m_clock_hz;
    logic [17:0] m_rate_hz;
    logic [15:0] m_freq    [3];
    logic [11:0] m_pw      [3];
    logic [7:0]  m_ctrl    [3];
    logic [7:0]  m_ad      [3];
    logic [7:0]  m_sr      [3];
    logic [23:0] m_acc     [3];
    logic [22:0] m_noise   [3];
    logic        m_gate    [3];
    logic        m_b19     [3];
    logic        m_msb     [3];
    logic        m_hold    [3];
    logic [1:0]  m_phase   [3];
    logic [7:0]  m_env     [3];
    logic [15:0] m_rate_ct [3];
    logic [7:0]  m_exp_ct  [3];
    logic [3:0]  m_master_vol;
    int unsigned m_fraction;

    task automatic synth_clear();
        for (int v = 0; v < 3; v++)
        begin
            m_freq[v] = '0; m_pw[v] = '0; m_ctrl[v] = '0; m_ad[v] = '0; m_sr[v] = '0;
            m_acc[v] = '0; m_noise[v] = LFSR_SEED;
            m_gate[v] = 0; m_b19[v] = 0; m_msb[v] = 0; m_hold[v] = 0;
            m_phase[v] = PH_RELEASE; m_env[v] = '0; m_rate_ct[v] = '0; m_exp_ct[v] = '0;
        end
        m_master_vol = '0;
        m_fraction   = 0;
    endtask

    function automatic int unsigned decay_div(logic [7:0] lvl);
        if (lvl > 8'h5D) return 1;
        if (lvl > 8'h36) return 2;
        if (lvl > 8'h1A) return 4;
        if (lvl > 8'h0E) return 8;
        if (lvl > 8'h06) return 16;
        if (lvl > 8'h00) return 30;
        return 1;
    endfunction

    task automatic synth_write(logic [4:0] addr, logic [7:0] data);
        int v;
        if (addr < REG_VOICE_END)
        begin
            v = addr / 7;
            case (3'(addr % 7))
                SLOT_FREQ_LO: m_freq[v][7:0]  = data;
                SLOT_FREQ_HI: m_freq[v][15:8] = data;
                SLOT_PW_LO:   m_pw[v][7:0]    = data;
                SLOT_PW_HI:   m_pw[v][11:8]   = data[3:0];
                SLOT_CTRL:
                begin
                    if (data[0] && !m_gate[v])
                    begin
                        m_phase[v] = PH_ATTACK;
                        m_hold[v]  = 0;
                    end
                    else if (!data[0] && m_gate[v])
                        m_phase[v] = PH_RELEASE;
                    m_gate[v] = data[0];
                    m_ctrl[v] = data;
                    if (data & CTRL_TEST)
                    begin
                        m_acc[v]   = '0;
                        m_noise[v] = LFSR_SEED;
                    end
                end
                SLOT_AD:      m_ad[v] = data;
                default:      m_sr[v] = data;
            endcase
        end
        else if (addr == REG_VOLUME)
            m_master_vol = data[3:0];
    endtask

    task automatic osc_tick(int v);
        logic b19;
        if (m_ctrl[v] & CTRL_TEST)
        begin
            m_acc[v] = '0;
            m_b19[v] = 0;
            m_msb[v] = 0;
            return;
        end
        m_acc[v] = m_acc[v] + 24'(m_freq[v]);
        b19 = m_acc[v][19];
        if (b19 && !m_b19[v])
            m_noise[v] = {m_noise[v][21:0], m_noise[v][22] ^ m_noise[v][17]};
        m_b19[v] = b19;
        m_msb[v] = m_acc[v][23];
    endtask

    task automatic env_tick(int v);
        logic [1:0] ph;
        logic [3:0] r;
        logic [7:0] sus;
        ph = m_phase[v];
        r  = (ph == PH_ATTACK) ? m_ad[v][7:4] : (ph == PH_DECAY) ? m_ad[v][3:0] : m_sr[v][3:0];
        m_rate_ct[v]++;
        if (m_rate_ct[v] < RATE_TICKS[r])
            return;
        m_rate_ct[v] = '0;
        if (ph == PH_ATTACK)
        begin
            if (m_env[v] < 8'hFF)
                m_env[v]++;
            if (m_env[v] == 8'hFF)
                m_phase[v] = PH_DECAY;
            return;
        end
        m_exp_ct[v]++;
        if (m_exp_ct[v] < decay_div(m_env[v]))
            return;
        m_exp_ct[v] = '0;
        if (m_hold[v])
            return;
        if (ph == PH_DECAY)
        begin
            sus = m_sr[v][7:4] * 8'h11;
            if (m_env[v] > sus)
                m_env[v]--;
            return;
        end
        if (m_env[v] > 0)
            m_env[v]--;
        if (m_env[v] == 0)
            m_hold[v] = 1;
    endtask

    function automatic int tone_level(int v, int src);
        logic [11:0] o;
        logic [23:0] ramp;
        logic        fold;
        o = 12'hFFF;
        if (m_ctrl[v][7:4] == 0 || m_env[v] == 0)
            return 0;
        if (m_ctrl[v][4])
        begin
            fold = m_acc[v][23];
            if (m_ctrl[v][2])
                fold ^= m_msb[src];
            ramp = fold ? ~m_acc[v] : m_acc[v];
            o &= ramp[22:11];
        end
        if (m_ctrl[v][5])
            o &= m_acc[v][23:12];
        if (m_ctrl[v][6])
            o &= ((m_ctrl[v] & CTRL_TEST) || m_acc[v][23:12] >= m_pw[v]) ? 12'hFFF : 12'h000;
        if (m_ctrl[v][7])
            o &= {m_noise[v][22], m_noise[v][20], m_noise[v][16], m_noise[v][13],
                  m_noise[v][11], m_noise[v][7], m_noise[v][4], m_noise[v][2], 4'b0000};
        return (int'(o) - 2048) * int'(m_env[v]);
    endfunction

    task automatic chip_tick();
        logic rose [3];
        logic was;
        for (int v = 0; v < 3; v++)
        begin
            was = m_msb[v];
            osc_tick(v);
            rose[v] = !was && m_msb[v];
        end
        // hard sync from the preceding voice
        for (int v = 0; v < 3; v++)
            if (m_ctrl[v][1] && rose[(v + 2) % 3])
                m_acc[v] = '0;
        for (int v = 0; v < 3; v++)
            env_tick(v);
    endtask

    task automatic render_sample(output logic [15:0] smp);
        int unsigned total, n;
        longint      sum, mixed;
        sum = 0;
        smp = '0;
        if (m_rate_hz == 0)
        begin
            m_fraction = 0;
            return;
        end
        total      = m_fraction + m_clock_hz;
        n          = total / m_rate_hz;
        m_fraction = total % m_rate_hz;
        if (n > 1024)
            n = 1024;
        if (n == 0)
            return;
        for (int c = 0; c < n; c++)
        begin
            chip_tick();
            for (int v = 0; v < 3; v++)
                sum += tone_level(v, (v + 2) % 3);
        end
        mixed = (sum / longint'(n)) * longint'(m_master_vol);
        mixed = mixed >>> SHIFT_BITS;
        smp   = mixed[15:0];
    endtask

    // ------------------------------------------------------------------
    // Expected samples and checking
    // ------------------------------------------------------------------
    logic [15:0] pending_samples[$];
    int          mismatches;
    int          samples_seen;
    int          words_sent;
    int          cycle_count;
    bit          quiet;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            samples_seen++;
            if (pending_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected sample word %0d", sample_out);
            end
            else if (pending_samples[0] !== sample_out)
            begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("sample %0d: expected %0d, got %0d", samples_seen,
                             $signed(pending_samples[0]), sample_out);
                void'(pending_samples.pop_front());
            end
            else
                void'(pending_samples.pop_front());
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output stalls in bursts
    int stall_left;
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready = 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 18);
            out_ready  = 1'b0;
        end
        else
            out_ready = 1'b1;
    end

    // ------------------------------------------------------------------
    // Drivers; tasks start and end just after a falling edge
    // ------------------------------------------------------------------
    task automatic send_word(logic [1:0] op, logic [4:0] addr, logic [7:0] data,
                             bit fixed, logic [15:0] fixed_val);
        logic [15:0] smp;
        int          gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            gap = $urandom_range(1, 18);
            repeat (gap) @(negedge clk);
        end
        in_valid         = 1'b1;
        operation        = op;
        register_address = addr;
        write_data       = data;
        do
            @(posedge clk);
        while (!in_ready);
        words_sent++;
        case (op)
            OP_WRITE:  synth_write(addr, data);
            OP_RENDER:
            begin
                render_sample(smp);
                pending_samples.push_back(fixed ? fixed_val : smp);
            end
            OP_CLEAR:  synth_clear();
            default:   ;
        endcase
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [21:0] val);
        cfg_write_enable = 1'b1;
        cfg_index        = idx;
        cfg_data         = val;
        @(negedge clk);
        cfg_write_enable = 1'b0;
        if (idx == CFG_CLOCK)
            m_clock_hz = val;
        else if (idx == CFG_RATE)
            m_rate_hz = val[17:0];
    endtask

    // hold the sender until every sample is back and the block has settled
    task automatic drain();
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic random_word();
        logic [1:0] op;
        logic [4:0] addr;
        logic [7:0] data;
        int         pick;
        pick = $urandom_range(0, 99);
        op   = (pick < 45) ? OP_RENDER : (pick < 92) ? OP_WRITE :
               (pick < 96) ? OP_CLEAR : OP_UNUSED;
        pick = $urandom_range(0, 9);
        addr = (pick < 8) ? 5'($urandom_range(0, 20)) : (pick == 8) ? REG_VOLUME :
               5'($urandom_range(0, 31));
        data = 8'($urandom);
        if (addr < REG_VOICE_END && 3'(addr % 7) == SLOT_CTRL && $urandom_range(0, 4) != 0)
            data &= ~CTRL_TEST;
        if (addr < REG_VOICE_END && 3'(addr % 7) == SLOT_AD && $urandom_range(0, 2) != 0)
            data[7:4] = 4'($urandom_range(0, 3));
        send_word(op, addr, data, 0, '0);
    endtask

    // directed rows
    typedef struct {
        logic [1:0]  op;
        logic [4:0]  addr;
        logic [7:0]  data;
        bit          fixed;
        logic [15:0] val;
    } stim_row_t;

    localparam int ROWS = 24;
    stim_row_t directed [ROWS] = '{
        '{OP_RENDER, 5'd0,  8'h00, 1, 16'd0},   // silent after reset
        '{OP_UNUSED, 5'd0,  8'h00, 0, 16'd0},   // unused operation
        '{OP_WRITE,  5'd31, 8'hFF, 0, 16'd0},   // ignored register
        '{OP_WRITE,  5'd21, 8'hAA, 0, 16'd0},   // filter register, ignored
        '{OP_WRITE,  REG_VOLUME, 8'hFF, 0, 16'd0},
        '{OP_WRITE,  5'd0,  8'hFF, 0, 16'd0},
        '{OP_WRITE,  5'd1,  8'hFF, 0, 16'd0},
        '{OP_WRITE,  5'd2,  8'hFF, 0, 16'd0},
        '{OP_WRITE,  5'd3,  8'hFF, 0, 16'd0},
        '{OP_WRITE,  5'd5,  8'h00, 0, 16'd0},
        '{OP_WRITE,  5'd6,  8'hF0, 0, 16'd0},
        '{OP_WRITE,  5'd4,  8'h11, 0, 16'd0},   // triangle, gate on
        '{OP_RENDER, 5'd0,  8'h00, 0, 16'd0},
        '{OP_WRITE,  5'd4,  8'h29, 0, 16'd0},   // saw with test bit
        '{OP_RENDER, 5'd0,  8'h00, 0, 16'd0},
        '{OP_WRITE,  5'd8,  8'h40, 0, 16'd0},
        '{OP_WRITE,  5'd11, 8'h83, 0, 16'd0},   // noise, sync, gate
        '{OP_WRITE,  5'd18, 8'h75, 0, 16'd0},   // combined waves, ring, gate
        '{OP_WRITE,  5'd4,  8'h45, 0, 16'd0},   // pulse with ring
        '{OP_RENDER, 5'd0,  8'h00, 0, 16'd0},
        '{OP_WRITE,  5'd4,  8'h10, 0, 16'd0},   // gate off, release
        '{OP_RENDER, 5'd0,  8'h00, 0, 16'd0},
        '{OP_CLEAR,  5'd0,  8'h00, 0, 16'd0},
        '{OP_RENDER, 5'd0,  8'h00, 1, 16'd0}    // silent after clear
    };

    // clock / rate pairs for the random phases, extremes and the odd cases included
    localparam int PHASES = 7;
    localparam logic [21:0] PH_CLOCK [PHASES] = '{
        22'd985248, 22'd4000000, 22'd100000, 22'd985248, 22'd4000000, 22'd1022727, 22'h3FFFFF
    };
    localparam logic [21:0] PH_RATE [PHASES] = '{
        22'd44100, 22'd8000, 22'd192000, 22'd0, 22'd1000, 22'd48000, 22'h3FFFF
    };
    localparam int PH_WORDS [PHASES] = '{140, 60, 70, 30, 25, 70, 130};

    initial
    begin
        rst_n            = 1'b0;
        cfg_write_enable = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        in_valid         = 1'b0;
        operation        = '0;
        register_address = '0;
        write_data       = '0;
        out_ready        = 1'b0;
        stall_left       = 0;
        mismatches       = 0;
        samples_seen     = 0;
        words_sent       = 0;
        cycle_count      = 0;
        quiet            = 0;
        m_clock_hz       = CLOCK_RESET;
        m_rate_hz        = RATE_RESET;
        synth_clear();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < ROWS; i++)
            send_word(directed[i].op, directed[i].addr, directed[i].data,
                      directed[i].fixed, directed[i].val);

        // random phases, each started from an idle block
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            cfg_write(CFG_CLOCK, PH_CLOCK[p]);
            cfg_write(CFG_RATE, PH_RATE[p]);
            if (p == 2)
                cfg_write(CFG_UNUSED, 22'h2AAAAA);    // out-of-range index, no effect
            if (p == PHASES - 1)
                quiet = 1;
            for (int k = 0; k < PH_WORDS[p]; k++)
                random_word();
        end

        drain();
        $display("sent %0d words over %0d clock/rate settings, checked %0d samples",
                 words_sent, PHASES + 1, samples_seen);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[filelist.f]
design/tvs_pkg.sv
design/tvs_div.sv
design/tvs_voice.sv
design/three_voice_sound_synth.sv
tb/tb_top.sv
